### src/emv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package emv_pkg;

    // Encoder geometry.
    localparam int ANGLE_BITS = 12;
    localparam int TURN_BITS  = 24;
    localparam int TOTAL_W    = TURN_BITS + ANGLE_BITS;

    // Velocity arithmetic widths.
    localparam int STAMP_W    = 32;
    localparam int VEL_W      = 32;
    localparam int QUOT_W     = 32;
    localparam int US_PER_S_W = 20;
    localparam int DELTA_W    = TURN_BITS + 1 + ANGLE_BITS;
    localparam int MAG_W      = TURN_BITS + ANGLE_BITS;
    localparam int ALU_W      = MAG_W + US_PER_S_W;
    localparam int SHIFT_W    = $clog2(US_PER_S_W);

    // One million is the sum of seven shifted copies of the magnitude.
    localparam int MUL_STEPS  = 7;
    localparam int MUL_IDX_W  = $clog2(MUL_STEPS);
    localparam int DIV_STEPS  = QUOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Configuration register widths and indexes.
    localparam int THR_W      = 12;
    localparam int ZTS_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TIME_SUBST    = 1'd1;

    localparam logic [THR_W-1:0] WRAP_THRESHOLD_RESET       = 12'd3276;
    localparam logic [ZTS_W-1:0] ZERO_TIME_SUBST_RESET      = 16'd1000;

    // Action codes of an input transaction.
    localparam logic [1:0] ACT_SAMPLE   = 2'd0;
    localparam logic [1:0] ACT_VELOCITY = 2'd1;
    localparam logic [1:0] ACT_REBASE   = 2'd2;

    typedef logic [1:0]                    action_t;
    typedef logic [ANGLE_BITS-1:0]         angle_t;
    typedef logic signed [TURN_BITS-1:0]   turns_t;
    typedef logic signed [TOTAL_W-1:0]     total_t;
    typedef logic [STAMP_W-1:0]            stamp_t;
    typedef logic signed [VEL_W-1:0]       velocity_t;

    localparam velocity_t VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam velocity_t VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_ELAPSED,
        ST_TURN_DIFF,
        ST_ANGLE_DIFF,
        ST_ABS,
        ST_MUL,
        ST_SAT,
        ST_DIV,
        ST_FINISH,
        ST_PUBLISH
    } state_t;

    // Shift of the magnitude for each partial product of the multiply by one million.
    function automatic logic [SHIFT_W-1:0] mul_shift(input logic [MUL_IDX_W-1:0] idx);
        logic [SHIFT_W-1:0] sh;
        case (idx)
            3'd0:    sh = SHIFT_W'(6);
            3'd1:    sh = SHIFT_W'(9);
            3'd2:    sh = SHIFT_W'(14);
            3'd3:    sh = SHIFT_W'(16);
            3'd4:    sh = SHIFT_W'(17);
            3'd5:    sh = SHIFT_W'(18);
            3'd6:    sh = SHIFT_W'(19);
            default: sh = '0;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

### src/emv_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface emv_sample_if;
    logic               valid;
    logic               ready;
    emv_pkg::action_t   action;
    emv_pkg::angle_t    raw_angle;
    logic               read_ok;
    emv_pkg::stamp_t    timestamp_us;

    modport source (output valid, output action, output raw_angle, output read_ok,
                    output timestamp_us, input ready);
    modport sink   (input valid, input action, input raw_angle, input read_ok,
                    input timestamp_us, output ready);
endinterface

interface emv_result_if;
    logic                 valid;
    logic                 ready;
    emv_pkg::angle_t      mechanical_angle;
    emv_pkg::turns_t      turn_count;
    emv_pkg::total_t      total_angle;
    emv_pkg::velocity_t   velocity;
    logic                 velocity_valid;

    modport source (output valid, output mechanical_angle, output turn_count,
                    output total_angle, output velocity, output velocity_valid,
                    input ready);
    modport sink   (input valid, input mechanical_angle, input turn_count,
                    input total_angle, input velocity, input velocity_valid,
                    output ready);
endinterface

`default_nettype wire

### src/encoder_multiturn_velocity_unit.sv
// Multi-turn tracker and velocity estimator for an absolute angle encoder.
// The samples channel carries one encoder reading per transaction: an action
// code, the raw single-turn angle, a read-ok flag and a microsecond timestamp.
// The results channel returns exactly one transaction per sample with the
// single-turn angle, the turn count, the multi-turn angle and, for a velocity
// request, the velocity in counts per second since the stored baseline.
// A plain write port (cfg_we, cfg_index, cfg_data) sets the wrap threshold and
// the substitute for a zero elapsed time; write it only while the block is idle.
// A sample-only or rebase transaction goes through the sample update and the
// publish state; the next sample is taken once the sequencer returns to idle.
// A velocity request runs further before it publishes: one shared 56-bit adder
// first forms the elapsed time, the count delta and its magnitude, then
// multiplies by one million in seven shift-and-add steps and runs a 32-step
// restoring division, which is skipped when the quotient saturates.
// Samples are accepted only while the sequencer is idle. The result sits in
// an output register, so a stalled receiver does not block the next sample;
// only a second finished result waits for it.
// Reset clears all tracking state to zero, unprimes the block and loads the
// register defaults (threshold 3276, substitute 1000 us).
`timescale 1ns / 1ps
`default_nettype none

module encoder_multiturn_velocity_unit (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [emv_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [emv_pkg::CFG_DATA_W-1:0]       cfg_data,
    emv_sample_if.sink                           samples,
    emv_result_if.source                         results
);
    import emv_pkg::*;

    // Sequencer state.
    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    // Configuration registers.
    logic [THR_W-1:0]       wrap_thr_reg;
    logic [ZTS_W-1:0]       zts_reg;

    // Tracking state and velocity baseline.
    angle_t                 last_angle_reg, last_angle_next;
    logic [TURN_BITS-1:0]   turns_reg, turns_next;
    stamp_t                 last_time_reg, last_time_next;
    angle_t                 base_angle_reg, base_angle_next;
    logic [TURN_BITS-1:0]   base_turns_reg, base_turns_next;
    stamp_t                 base_time_reg, base_time_next;
    logic                   primed_reg, primed_next;

    // Captured input transaction.
    action_t                action_reg;
    angle_t                 raw_reg;
    logic                   ok_reg;
    stamp_t                 stamp_reg;

    // Arithmetic working registers.
    logic [ALU_W-1:0]       acc_reg, acc_next;
    logic [MAG_W-1:0]       mag_reg, mag_next;
    logic [QUOT_W-1:0]      rem_reg, rem_next;
    logic [QUOT_W-1:0]      divisor_reg, divisor_next;
    logic                   neg_reg, neg_next;
    logic                   ovf_reg, ovf_next;
    velocity_t              vel_reg, vel_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    angle_t                 out_angle_reg;
    logic [TURN_BITS-1:0]   out_turns_reg;
    velocity_t              out_vel_reg;
    logic                   out_vel_valid_reg;

    // Shared adder: subtract mode gives a - b with the carry out set when a >= b.
    logic [ALU_W-1:0]       alu_a, alu_b;
    logic                   alu_sub;
    logic [ALU_W:0]         alu_sum;

    // Per-sample decode.
    logic [ANGLE_BITS:0]    fwd_diff;
    logic [ANGLE_BITS:0]    back_diff;
    logic                   jump_up;
    logic [ANGLE_BITS-1:0]  jump_mag;
    logic                   crossing;
    logic [QUOT_W-1:0]      quot;
    logic                   publish;
    logic                   accept;

    assign accept  = samples.valid && samples.ready;
    assign publish = (state_reg == ST_PUBLISH) && (!out_valid_reg || results.ready);

    assign samples.ready            = (state_reg == ST_IDLE);
    assign results.valid            = out_valid_reg;
    assign results.mechanical_angle = out_angle_reg;
    assign results.turn_count       = out_turns_reg;
    assign results.total_angle      = {out_turns_reg, out_angle_reg};
    assign results.velocity         = out_vel_reg;
    assign results.velocity_valid   = out_vel_valid_reg;

    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{ALU_W{1'b0}}, alu_sub};

    // Wrap test against the previous angle. A positive jump is raw above last.
    assign fwd_diff  = {1'b0, raw_reg} - {1'b0, last_angle_reg};
    assign back_diff = {1'b0, last_angle_reg} - {1'b0, raw_reg};
    assign jump_up   = !fwd_diff[ANGLE_BITS] && (fwd_diff != '0);
    assign jump_mag  = jump_up ? fwd_diff[ANGLE_BITS-1:0] : back_diff[ANGLE_BITS-1:0];
    assign crossing  = (jump_mag > wrap_thr_reg);

    assign quot = acc_reg[QUOT_W-1:0];

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SAMPLE;
                end
            end
            ST_SAMPLE:
            begin
                if (action_reg == ACT_VELOCITY)
                begin
                    state_next = ST_ELAPSED;
                end
                else
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_ELAPSED:    state_next = ST_TURN_DIFF;
            ST_TURN_DIFF:  state_next = ST_ANGLE_DIFF;
            ST_ANGLE_DIFF: state_next = ST_ABS;
            ST_ABS:        state_next = ST_MUL;
            ST_MUL:
            begin
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                // A quotient of 2^32 or more saturates without dividing.
                if (alu_sum[ALU_W])
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:     state_next = ST_PUBLISH;
            ST_PUBLISH:
            begin
                if (publish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Datapath control: operand selection of the shared adder and register updates.
    always_comb
    begin
        step_next       = step_reg;
        last_angle_next = last_angle_reg;
        turns_next      = turns_reg;
        last_time_next  = last_time_reg;
        base_angle_next = base_angle_reg;
        base_turns_next = base_turns_reg;
        base_time_next  = base_time_reg;
        primed_next     = primed_reg;
        acc_next        = acc_reg;
        mag_next        = mag_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        neg_next        = neg_reg;
        ovf_next        = ovf_reg;
        vel_next        = vel_reg;
        alu_a           = '0;
        alu_b           = '0;
        alu_sub         = 1'b0;

        case (state_reg)
            ST_SAMPLE:
            begin
                last_time_next = stamp_reg;
                vel_next       = '0;
                if (ok_reg)
                begin
                    last_angle_next = raw_reg;
                    if (!primed_reg)
                    begin
                        primed_next = 1'b1;
                    end
                    else if (crossing)
                    begin
                        // A forward jump past the threshold is a crossing backward.
                        turns_next = jump_up ? (turns_reg - 1'b1) : (turns_reg + 1'b1);
                    end
                end
                if ((ok_reg && !primed_reg) || (action_reg == ACT_REBASE))
                begin
                    base_angle_next = last_angle_next;
                    base_turns_next = turns_next;
                    base_time_next  = last_time_next;
                end
            end
            ST_ELAPSED:
            begin
                alu_a   = ALU_W'(last_time_reg);
                alu_b   = ALU_W'(base_time_reg);
                alu_sub = 1'b1;
                if (alu_sum[STAMP_W-1:0] != '0)
                begin
                    divisor_next = alu_sum[QUOT_W-1:0];
                end
                else if (zts_reg != '0)
                begin
                    divisor_next = QUOT_W'(zts_reg);
                end
                else
                begin
                    divisor_next = QUOT_W'(1);
                end
            end
            ST_TURN_DIFF:
            begin
                alu_a    = {{(ALU_W-TURN_BITS){turns_reg[TURN_BITS-1]}}, turns_reg};
                alu_b    = {{(ALU_W-TURN_BITS){base_turns_reg[TURN_BITS-1]}}, base_turns_reg};
                alu_sub  = 1'b1;
                acc_next = alu_sum[ALU_W-1:0];
            end
            ST_ANGLE_DIFF:
            begin
                // Turn difference with the angle appended is the count delta before
                // the base angle is taken off.
                alu_a    = {{(ALU_W-DELTA_W){acc_reg[TURN_BITS]}}, acc_reg[TURN_BITS:0],
                            last_angle_reg};
                alu_b    = ALU_W'(base_angle_reg);
                alu_sub  = 1'b1;
                acc_next = alu_sum[ALU_W-1:0];
            end
            ST_ABS:
            begin
                neg_next = acc_reg[DELTA_W-1];
                if (acc_reg[DELTA_W-1])
                begin
                    alu_a   = '0;
                    alu_b   = acc_reg;
                    alu_sub = 1'b1;
                end
                else
                begin
                    alu_a = acc_reg;
                end
                mag_next  = alu_sum[MAG_W-1:0];
                acc_next  = '0;
                step_next = '0;
            end
            ST_MUL:
            begin
                alu_a     = acc_reg;
                alu_b     = ALU_W'(mag_reg) << mul_shift(step_reg[MUL_IDX_W-1:0]);
                acc_next  = alu_sum[ALU_W-1:0];
                step_next = (step_reg == STEP_W'(MUL_STEPS - 1)) ? '0 : step_reg + 1'b1;
            end
            ST_SAT:
            begin
                alu_a     = ALU_W'(acc_reg[ALU_W-1:QUOT_W]);
                alu_b     = ALU_W'(divisor_reg);
                alu_sub   = 1'b1;
                ovf_next  = alu_sum[ALU_W];
                rem_next  = QUOT_W'(acc_reg[ALU_W-1:QUOT_W]);
                step_next = '0;
            end
            ST_DIV:
            begin
                alu_a     = ALU_W'({rem_reg, acc_reg[QUOT_W-1]});
                alu_b     = ALU_W'(divisor_reg);
                alu_sub   = 1'b1;
                rem_next  = alu_sum[ALU_W] ? alu_sum[QUOT_W-1:0] : {rem_reg[QUOT_W-2:0],
                                                                   acc_reg[QUOT_W-1]};
                acc_next  = {acc_reg[ALU_W-1:QUOT_W], acc_reg[QUOT_W-2:0], alu_sum[ALU_W]};
                step_next = step_reg + 1'b1;
            end
            ST_FINISH:
            begin
                alu_a   = '0;
                alu_b   = ALU_W'(quot);
                alu_sub = 1'b1;
                if (ovf_reg)
                begin
                    vel_next = neg_reg ? VEL_MIN : VEL_MAX;
                end
                else if (neg_reg)
                begin
                    vel_next = (quot[QUOT_W-1] && (quot[QUOT_W-2:0] != '0))
                             ? VEL_MIN : velocity_t'(alu_sum[VEL_W-1:0]);
                end
                else
                begin
                    vel_next = quot[QUOT_W-1] ? VEL_MAX : velocity_t'(quot);
                end
                base_angle_next = last_angle_reg;
                base_turns_next = turns_reg;
                base_time_next  = last_time_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            wrap_thr_reg   <= WRAP_THRESHOLD_RESET;
            zts_reg        <= ZERO_TIME_SUBST_RESET;
            last_angle_reg <= '0;
            turns_reg      <= '0;
            last_time_reg  <= '0;
            base_angle_reg <= '0;
            base_turns_reg <= '0;
            base_time_reg  <= '0;
            primed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            last_angle_reg <= last_angle_next;
            turns_reg      <= turns_next;
            last_time_reg  <= last_time_next;
            base_angle_reg <= base_angle_next;
            base_turns_reg <= base_turns_next;
            base_time_reg  <= base_time_next;
            primed_reg     <= primed_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_WRAP_THRESHOLD))
            begin
                wrap_thr_reg <= cfg_data[THR_W-1:0];
            end
            if (cfg_we && (cfg_index == CFG_ZERO_TIME_SUBST))
            begin
                zts_reg <= cfg_data[ZTS_W-1:0];
            end
        end
    end

    // Payload and arithmetic registers carry no reset.
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        mag_reg     <= mag_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        ovf_reg     <= ovf_next;
        vel_reg     <= vel_next;
        if (accept)
        begin
            action_reg <= samples.action;
            raw_reg    <= samples.raw_angle;
            ok_reg     <= samples.read_ok;
            stamp_reg  <= samples.timestamp_us;
        end
        if (publish)
        begin
            out_angle_reg     <= last_angle_reg;
            out_turns_reg     <= turns_reg;
            out_vel_reg       <= vel_reg;
            out_vel_valid_reg <= (action_reg == ACT_VELOCITY);
        end
    end

    // The partial remainder stays below the divisor throughout the division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < divisor_reg))
        else $error("division remainder reached the divisor");

    // The elapsed-time divisor is never zero once it is in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SAT) || (state_reg == ST_DIV) || (state_reg == ST_FINISH))
        |-> (divisor_reg != '0))
        else $error("zero divisor in velocity computation");

    // A result without a fresh velocity reports zero velocity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.velocity_valid) |-> (results.velocity == '0))
        else $error("stale velocity on a sample-only result");

    // An accepted transaction starts the sample update on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SAMPLE))
        else $error("accepted sample not processed");

endmodule

`default_nettype wire
